@@ design/dns_response_address_extractor_assert.svh @@
// assertion macros used by the dns response address extractor parser (dre_parser)
// no dependencies; expects a clock and an active-high reset to be passed in
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_ASSERT_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DRE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dre assertion failed");

// antecedent implies consequent in the next cycle
`define DRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dre assertion failed");

`endif

@@ design/dre_pkg.sv @@
// shared types and constants for the dns response address extractor
// no dependencies
package dre_pkg;

  // parse phase codes
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QNAME  = 4'd1;
  localparam logic [3:0] PH_QFIXED = 4'd2;
  localparam logic [3:0] PH_ANAME  = 4'd3;
  localparam logic [3:0] PH_APTR   = 4'd4;
  localparam logic [3:0] PH_ASTR   = 4'd5;
  localparam logic [3:0] PH_AFIXED = 4'd6;
  localparam logic [3:0] PH_ADATA  = 4'd7;
  localparam logic [3:0] PH_ASKIP  = 4'd8;
  localparam logic [3:0] PH_DONE   = 4'd9;

  // result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  localparam int unsigned HEADER_LEN  = 12;
  localparam logic [15:0] ID_RESET    = 16'h1234;
  localparam logic [7:0]  PTR_MARK    = 8'hC0;
  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] ADDR_LEN    = 16'd4;
  localparam logic [15:0] QFIXED_LEN  = 16'd4;
  localparam logic [15:0] AFIXED_LEN  = 16'd10;
  localparam logic [15:0] RLEN_FIRST  = 16'd8;
  localparam logic [15:0] RTYPE_END   = 16'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } result_t;

endpackage

@@ design/dre_in_reg.sv @@
// input register stage: holds one accepted byte until the parser takes it
// depends on dre_pkg
module dre_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          consume,
  output logic          item_valid,
  output dre_pkg::item_t item
);

  logic accept;

  assign in_stall = item_valid && !consume;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data <= data_byte;
      item.last <= last_byte;
    end
  end

endmodule

@@ design/dre_parser.sv @@
// per-byte datagram parser: header check, question and answer skipping,
// address capture and end-of-datagram result; depends on dre_pkg and the assert header
`include "dns_response_address_extractor_assert.svh"

module dre_parser #(
  parameter int unsigned MAX_DATAGRAM = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      expected_id,
  input  logic             item_valid,
  input  dre_pkg::item_t   item,
  input  logic             out_free,
  output logic             consume,
  output logic             result_load,
  output dre_pkg::result_t result
);

  localparam int unsigned PW = $clog2(MAX_DATAGRAM + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_DATAGRAM);

  logic [PW-1:0] byte_position, byte_position_next;
  logic [3:0]    parse_phase, parse_phase_next;
  logic [15:0]   questions_left, questions_left_next;
  logic [15:0]   answers_left, answers_left_next;
  logic [15:0]   skip_count, skip_count_next;
  logic [15:0]   record_type, record_type_next;
  logic [15:0]   record_length, record_length_next;
  logic [31:0]   address_accum, address_accum_next;
  logic          id_matches, id_matches_next;
  logic          address_found, address_found_next;

  logic [7:0]  b;
  logic [15:0] skip_dec, skip_inc, q_dec, a_dec, rt_upd, rl_upd;

  assign consume     = item_valid && out_free;
  assign result_load = consume && item.last;
  assign b           = item.data;
  assign skip_dec    = skip_count - 16'd1;
  assign skip_inc    = skip_count + 16'd1;
  assign q_dec       = questions_left - 16'd1;
  assign a_dec       = answers_left - 16'd1;

  // type and length as they stand after this byte of the fixed answer part
  always_comb begin
    rt_upd = record_type;
    rl_upd = record_length;
    if (skip_count < dre_pkg::RTYPE_END) begin
      rt_upd = {record_type[7:0], b};
    end else if (skip_count >= dre_pkg::RLEN_FIRST) begin
      rl_upd = {record_length[7:0], b};
    end
  end

  always_comb begin
    byte_position_next  = byte_position;
    parse_phase_next    = parse_phase;
    questions_left_next = questions_left;
    answers_left_next   = answers_left;
    skip_count_next     = skip_count;
    record_type_next    = record_type;
    record_length_next  = record_length;
    address_accum_next  = address_accum;
    id_matches_next     = id_matches;
    address_found_next  = address_found;
    result.status       = dre_pkg::ST_IGNORED;
    result.addr         = 32'd0;

    // bytes past the buffer size are dropped, position saturates
    if (consume && byte_position < POS_MAX) begin
      byte_position_next = byte_position + PW'(1);
      unique case (parse_phase)
        dre_pkg::PH_HEADER: begin
          if (byte_position == PW'(0)) begin
            id_matches_next = (b == expected_id[15:8]);
          end else if (byte_position == PW'(1)) begin
            id_matches_next = id_matches && (b == expected_id[7:0]);
          end else if (byte_position == PW'(4) || byte_position == PW'(5)) begin
            questions_left_next = {questions_left[7:0], b};
          end else if (byte_position == PW'(6) || byte_position == PW'(7)) begin
            answers_left_next = {answers_left[7:0], b};
          end
          if (byte_position == PW'(dre_pkg::HEADER_LEN - 1)) begin
            priority if (answers_left == 16'd0) begin
              parse_phase_next = dre_pkg::PH_DONE;
            end else if (questions_left == 16'd0) begin
              parse_phase_next = dre_pkg::PH_ANAME;
            end else begin
              parse_phase_next = dre_pkg::PH_QNAME;
            end
          end
        end
        dre_pkg::PH_QNAME: begin
          if (b == 8'd0) begin
            parse_phase_next = dre_pkg::PH_QFIXED;
            skip_count_next  = dre_pkg::QFIXED_LEN;
          end
        end
        dre_pkg::PH_QFIXED: begin
          skip_count_next = skip_dec;
          if (skip_dec == 16'd0) begin
            questions_left_next = q_dec;
            parse_phase_next = (q_dec == 16'd0) ? dre_pkg::PH_ANAME : dre_pkg::PH_QNAME;
          end
        end
        dre_pkg::PH_ANAME: begin
          priority if ((b & dre_pkg::PTR_MARK) == dre_pkg::PTR_MARK) begin
            parse_phase_next = dre_pkg::PH_APTR;
          end else if (b == 8'd0) begin
            parse_phase_next = dre_pkg::PH_AFIXED;
            skip_count_next  = 16'd0;
          end else begin
            parse_phase_next = dre_pkg::PH_ASTR;
          end
        end
        dre_pkg::PH_APTR: begin
          parse_phase_next = dre_pkg::PH_AFIXED;
          skip_count_next  = 16'd0;
        end
        dre_pkg::PH_ASTR: begin
          if (b == 8'd0) begin
            parse_phase_next = dre_pkg::PH_AFIXED;
            skip_count_next  = 16'd0;
          end
        end
        dre_pkg::PH_AFIXED: begin
          record_type_next   = rt_upd;
          record_length_next = rl_upd;
          skip_count_next    = skip_inc;
          if (skip_inc >= dre_pkg::AFIXED_LEN) begin
            priority if (rt_upd == dre_pkg::TYPE_A && rl_upd == dre_pkg::ADDR_LEN) begin
              parse_phase_next   = dre_pkg::PH_ADATA;
              skip_count_next    = 16'd0;
              address_accum_next = 32'd0;
            end else if (rl_upd == 16'd0) begin
              answers_left_next = a_dec;
              parse_phase_next = (a_dec == 16'd0) ? dre_pkg::PH_DONE : dre_pkg::PH_ANAME;
            end else begin
              parse_phase_next = dre_pkg::PH_ASKIP;
              skip_count_next  = rl_upd;
            end
          end
        end
        dre_pkg::PH_ADATA: begin
          address_accum_next = {address_accum[23:0], b};
          skip_count_next    = skip_inc;
          if (skip_inc >= dre_pkg::ADDR_LEN) begin
            address_found_next = 1'b1;
            parse_phase_next   = dre_pkg::PH_DONE;
          end
        end
        dre_pkg::PH_ASKIP: begin
          skip_count_next = skip_dec;
          if (skip_dec == 16'd0) begin
            answers_left_next = a_dec;
            parse_phase_next = (a_dec == 16'd0) ? dre_pkg::PH_DONE : dre_pkg::PH_ANAME;
          end
        end
        default: begin
        end
      endcase
    end

    // end of datagram: classify, then return to the header state
    if (result_load) begin
      priority if (byte_position_next < PW'(dre_pkg::HEADER_LEN) || !id_matches_next) begin
        result.status = dre_pkg::ST_IGNORED;
      end else if (address_found_next) begin
        result.status = dre_pkg::ST_FOUND;
        result.addr   = address_accum_next;
      end else begin
        result.status = dre_pkg::ST_NONE;
      end
      byte_position_next  = '0;
      parse_phase_next    = dre_pkg::PH_HEADER;
      questions_left_next = 16'd0;
      answers_left_next   = 16'd0;
      skip_count_next     = 16'd0;
      record_type_next    = 16'd0;
      record_length_next  = 16'd0;
      address_accum_next  = 32'd0;
      id_matches_next     = 1'b0;
      address_found_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      parse_phase    <= dre_pkg::PH_HEADER;
      questions_left <= 16'd0;
      answers_left   <= 16'd0;
      skip_count     <= 16'd0;
      record_type    <= 16'd0;
      record_length  <= 16'd0;
      address_accum  <= 32'd0;
      id_matches     <= 1'b0;
      address_found  <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      parse_phase    <= parse_phase_next;
      questions_left <= questions_left_next;
      answers_left   <= answers_left_next;
      skip_count     <= skip_count_next;
      record_type    <= record_type_next;
      record_length  <= record_length_next;
      address_accum  <= address_accum_next;
      id_matches     <= id_matches_next;
      address_found  <= address_found_next;
    end
  end

  `DRE_ASSERT_NEXT(a_clear_after_last, clk, rst, result_load,
                   byte_position == '0 && parse_phase == dre_pkg::PH_HEADER)
  `DRE_ASSERT_SAME(a_addr_zero_unless_found, clk, rst,
                   result_load && result.status != dre_pkg::ST_FOUND, result.addr == 32'd0)
  `DRE_ASSERT_SAME(a_pos_saturates, clk, rst, 1'b1, byte_position <= POS_MAX)
  `DRE_ASSERT_SAME(a_adata_bound, clk, rst, parse_phase == dre_pkg::PH_ADATA,
                   skip_count < dre_pkg::ADDR_LEN && !address_found)

endmodule

@@ design/dre_out_reg.sv @@
// result register: holds one result until the consumer takes it
// depends on dre_pkg
module dre_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             result_load,
  input  dre_pkg::result_t result,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [31:0]      ipv4_address
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      status       <= result.status;
      ipv4_address <= result.addr;
    end
  end

endmodule

@@ design/dns_response_address_extractor.sv @@
// dns response address extractor: one datagram byte per transaction, one result per datagram
// a result is registered in dre_out_reg when the parser consumes its last byte from the input register
// throughput: one byte per cycle; bytes wait while a finished result is held by out_stall
// reset (rst, synchronous): clears parse state and handshakes, expected_id returns to 0x1234
// depends on dre_pkg, dre_in_reg, dre_parser, dre_out_reg
module dns_response_address_extractor #(
  parameter int unsigned MAX_DATAGRAM = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] ipv4_address
);

  logic [15:0]      expected_id;
  logic             item_valid;
  dre_pkg::item_t   item;
  logic             consume;
  logic             out_free;
  logic             result_load;
  dre_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= dre_pkg::ID_RESET;
    end else if (cfg_we) begin
      expected_id <= cfg_wdata;
    end
  end

  dre_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  dre_parser #(
    .MAX_DATAGRAM (MAX_DATAGRAM)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .expected_id (expected_id),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (out_free),
    .consume     (consume),
    .result_load (result_load),
    .result      (result)
  );

  dre_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .result_load  (result_load),
    .result       (result),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .ipv4_address (ipv4_address)
  );

endmodule

@@ test/dre_checker.sv @@
`timescale 1ns / 1ps
// checker for the dns response address extractor: follows each datagram byte by byte,
// queues the result it predicts and compares every accepted result; depends on dre_pkg
module dre_checker
  import dre_pkg::*;
#(
  parameter int unsigned MAX_DATAGRAM = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [31:0] ipv4_address,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned MAX_REPORTS = 10;

  logic [15:0] id_reg;
  logic [9:0]  dg_pos;
  logic [3:0]  dg_phase;
  logic [15:0] questions_todo;
  logic [15:0] answers_todo;
  logic [15:0] countdown;
  logic [15:0] rr_type;
  logic [15:0] rr_len;
  logic [31:0] addr_acc;
  logic        id_ok;
  logic        addr_done;

  result_t     expected_replies[$];
  int unsigned mismatches;

  task automatic clear_datagram();
    dg_pos         = '0;
    dg_phase       = PH_HEADER;
    questions_todo = '0;
    answers_todo   = '0;
    countdown      = '0;
    rr_type        = '0;
    rr_len         = '0;
    addr_acc       = '0;
    id_ok          = 1'b0;
    addr_done      = 1'b0;
  endtask

  task automatic next_answer();
    answers_todo = answers_todo - 16'd1;
    dg_phase = (answers_todo == 16'd0) ? PH_DONE : PH_ANAME;
  endtask

  task automatic advance_parse(input logic [7:0] b);
    case (dg_phase)
      PH_HEADER: begin
        case (dg_pos)
          10'd0: id_ok = (b == id_reg[15:8]);
          10'd1: id_ok = id_ok && (b == id_reg[7:0]);
          10'd4, 10'd5: questions_todo = {questions_todo[7:0], b};
          10'd6, 10'd7: answers_todo = {answers_todo[7:0], b};
          default: ;
        endcase
        if (dg_pos == HEADER_LEN - 1) begin
          if (answers_todo == 16'd0) dg_phase = PH_DONE;
          else if (questions_todo == 16'd0) dg_phase = PH_ANAME;
          else dg_phase = PH_QNAME;
        end
      end
      PH_QNAME: begin
        if (b == 8'h00) begin
          dg_phase  = PH_QFIXED;
          countdown = QFIXED_LEN;
        end
      end
      PH_QFIXED: begin
        countdown = countdown - 16'd1;
        if (countdown == 16'd0) begin
          questions_todo = questions_todo - 16'd1;
          dg_phase = (questions_todo == 16'd0) ? PH_ANAME : PH_QNAME;
        end
      end
      PH_ANAME: begin
        if ((b & PTR_MARK) == PTR_MARK) dg_phase = PH_APTR;
        else if (b == 8'h00) begin
          dg_phase  = PH_AFIXED;
          countdown = '0;
        end else dg_phase = PH_ASTR;
      end
      PH_APTR: begin
        dg_phase  = PH_AFIXED;
        countdown = '0;
      end
      PH_ASTR: begin
        if (b == 8'h00) begin
          dg_phase  = PH_AFIXED;
          countdown = '0;
        end
      end
      PH_AFIXED: begin
        // type in the first two bytes, data length in the last two
        if (countdown < RTYPE_END) rr_type = {rr_type[7:0], b};
        else if (countdown >= RLEN_FIRST) rr_len = {rr_len[7:0], b};
        countdown = countdown + 16'd1;
        if (countdown >= AFIXED_LEN) begin
          if (rr_type == TYPE_A && rr_len == ADDR_LEN) begin
            dg_phase  = PH_ADATA;
            countdown = '0;
            addr_acc  = '0;
          end else if (rr_len == 16'd0) begin
            next_answer();
          end else begin
            dg_phase  = PH_ASKIP;
            countdown = rr_len;
          end
        end
      end
      PH_ADATA: begin
        addr_acc  = {addr_acc[23:0], b};
        countdown = countdown + 16'd1;
        if (countdown >= ADDR_LEN) begin
          addr_done = 1'b1;
          dg_phase  = PH_DONE;
        end
      end
      PH_ASKIP: begin
        countdown = countdown - 16'd1;
        if (countdown == 16'd0) next_answer();
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      id_reg = ID_RESET;
      clear_datagram();
      expected_replies.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          note_mismatch("result with none pending, status", '0, status);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status) note_mismatch("status", want.status, status);
          if (ipv4_address !== want.addr) note_mismatch("ipv4 address", want.addr, ipv4_address);
        end
      end
      if (cfg_we) id_reg = cfg_wdata;
      if (in_valid && !in_stall) begin
        // bytes past the buffer are dropped, the position saturates
        if (dg_pos < MAX_DATAGRAM) begin
          advance_parse(data_byte);
          dg_pos = dg_pos + 10'd1;
        end
        if (last_byte) begin
          if (dg_pos < HEADER_LEN || !id_ok) begin
            want.status = ST_IGNORED;
            want.addr   = '0;
          end else if (addr_done) begin
            want.status = ST_FOUND;
            want.addr   = addr_acc;
          end else begin
            want.status = ST_NONE;
            want.addr   = '0;
          end
          expected_replies.push_back(want);
          clear_datagram();
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_replies.size();
  end

endmodule

@@ test/tb_dns_response_address_extractor.sv @@
`timescale 1ns / 1ps
// testbench top for the dns response address extractor: drives datagrams byte by byte,
// random stalls on both sides and id register changes; depends on dre_pkg and dre_checker
module tb_dns_response_address_extractor;
  import dre_pkg::*;

  localparam int unsigned MAX_BYTES      = 512;
  localparam int unsigned RANDOM_BYTES   = 400;
  localparam int unsigned PHASES         = 5;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // answer name encodings
  localparam int unsigned NAME_ROOT = 0;
  localparam int unsigned NAME_PTR  = 1;
  localparam int unsigned NAME_STR  = 2;

  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_AAAA  = 16'd28;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] ipv4_address;

  int unsigned fail_count;
  int unsigned pending;

  bit          in_fire;
  bit          out_fire;
  bit          quiet;
  bit          hold_req;
  logic [15:0] cur_id;
  logic [7:0]  frame[$];
  int unsigned bytes_sent;

  dns_response_address_extractor #(
    .MAX_DATAGRAM(MAX_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .ipv4_address(ipv4_address)
  );

  dre_checker #(
    .MAX_DATAGRAM(MAX_BYTES)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .ipv4_address(ipv4_address),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshakes seen at the rising edge, read back at the falling edge
  always @(posedge clk) begin
    in_fire  <= in_valid && !in_stall;
    out_fire <= out_valid && !out_stall;
  end

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stall bursts, one long hold when asked
  initial begin : receiver
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = quiet ? 0 : idle_len();
        if (n == 0) out_stall <= 1'b0;
        else begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic put16(input logic [15:0] v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] qd, input logic [15:0] an);
    put16(id);
    put16(16'($urandom));
    put16(qd);
    put16(an);
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  // n nonzero bytes and the terminating zero
  task automatic put_label_name(input int unsigned n);
    repeat (n) frame.push_back(8'($urandom_range(1, 255)));
    frame.push_back(8'h00);
  endtask

  task automatic put_question();
    put_label_name($urandom_range(0, 12));
    put16(16'($urandom));
    put16(16'($urandom));
  endtask

  // at most 16 data bytes, so a huge length runs off the datagram end
  task automatic put_answer(input int unsigned name_kind, input logic [15:0] rtype,
                            input logic [15:0] rlen);
    case (name_kind)
      NAME_PTR: begin
        frame.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
        frame.push_back(8'($urandom));
      end
      NAME_STR: begin
        frame.push_back(8'($urandom_range(1, 8'hBF)));
        put_label_name($urandom_range(0, 10));
      end
      default: frame.push_back(8'h00);
    endcase
    put16(rtype);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    put16(rlen);
    for (int k = 0; k < rlen && k < 16; k++) frame.push_back(8'($urandom));
  endtask

  task automatic set_tail(input logic [7:0] v);
    for (int k = 1; k <= 4; k++) frame[frame.size() - k] = v;
  endtask

  task automatic cut_to(input int unsigned n);
    while (frame.size() > n) void'(frame.pop_back());
  endtask

  task automatic pad_to(input int unsigned n);
    while (frame.size() < n) frame.push_back(8'($urandom));
  endtask

  task automatic build_random();
    logic [15:0] id;
    logic [15:0] qd;
    logic [15:0] an;
    logic [15:0] rtype;
    logic [15:0] rlen;
    int unsigned roll;
    int unsigned nq;
    int unsigned na;
    frame.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
      return;
    end
    id = ($urandom_range(0, 9) == 0) ? cur_id ^ 16'($urandom_range(1, 16'hFFFF)) : cur_id;
    qd = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
    an = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    put_header(id, qd, an);
    nq = (qd > 3) ? $urandom_range(0, 3) : qd;
    repeat (nq) put_question();
    na = (an > 5) ? $urandom_range(1, 5) : an;
    repeat (na) begin
      roll = $urandom_range(0, 9);
      if (roll < 5) rtype = TYPE_A;
      else if (roll < 7) rtype = TYPE_CNAME;
      else if (roll < 8) rtype = TYPE_AAAA;
      else rtype = 16'($urandom);
      if ($urandom_range(0, 9) == 0) rlen = 16'($urandom);
      else if (rtype == TYPE_A && $urandom_range(0, 3) != 0) rlen = ADDR_LEN;
      else rlen = 16'($urandom_range(0, 12));
      put_answer($urandom_range(NAME_ROOT, NAME_STR), rtype, rlen);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 15) cut_to($urandom_range(1, frame.size()));
    else if (roll < 16) pad_to($urandom_range(MAX_BYTES + 1, MAX_BYTES + 24));
  endtask

  // holds the byte until it is taken; valid stays high into the next byte when there is no gap
  task automatic offer_byte(input logic [7:0] b, input logic l);
    int unsigned n;
    n = quiet ? 0 : idle_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(negedge clk); while (!in_fire);
    bytes_sent++;
  endtask

  task automatic send_datagram();
    quiet = ($urandom_range(0, 5) == 0);
    foreach (frame[k]) offer_byte(frame[k], k == frame.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_id(input logic [15:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_id = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] phase_ids[PHASES];
    int unsigned target;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    data_byte  = '0;
    last_byte  = 1'b0;
    cur_id     = ID_RESET;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lone byte, then a header one byte short
    frame.delete();
    frame.push_back(8'($urandom));
    send_datagram();
    frame.delete();
    put_header(cur_id, 16'd0, 16'd1);
    cut_to(HEADER_LEN - 1);
    send_datagram();
    // bare header with no answers
    frame.delete();
    put_header(cur_id, 16'd0, 16'd0);
    send_datagram();
    // foreign id in the high byte, then in the low byte
    frame.delete();
    put_header(cur_id ^ 16'h8000, 16'd0, 16'd1);
    put_answer(NAME_PTR, TYPE_A, ADDR_LEN);
    send_datagram();
    frame.delete();
    put_header(cur_id ^ 16'h0001, 16'd0, 16'd1);
    put_answer(NAME_PTR, TYPE_A, ADDR_LEN);
    send_datagram();
    // pointer name with all-ones address, root name with all-zero address
    frame.delete();
    put_header(cur_id, 16'd1, 16'd1);
    put_question();
    put_answer(NAME_PTR, TYPE_A, ADDR_LEN);
    set_tail(8'hFF);
    send_datagram();
    frame.delete();
    put_header(cur_id, 16'd0, 16'd1);
    put_answer(NAME_ROOT, TYPE_A, ADDR_LEN);
    set_tail(8'h00);
    send_datagram();
    // alias, empty record and six-byte A record skipped before the address
    frame.delete();
    put_header(cur_id, 16'd2, 16'd4);
    put_question();
    put_question();
    put_answer(NAME_STR, TYPE_CNAME, 16'd6);
    put_answer(NAME_PTR, TYPE_AAAA, 16'd0);
    put_answer(NAME_ROOT, TYPE_A, 16'd6);
    put_answer(NAME_STR, TYPE_A, ADDR_LEN);
    send_datagram();
    // no usable answer
    frame.delete();
    put_header(cur_id, 16'd0, 16'd2);
    put_answer(NAME_PTR, TYPE_A, 16'd0);
    put_answer(NAME_STR, TYPE_CNAME, ADDR_LEN);
    send_datagram();
    // ends inside a question, inside the fixed answer part, inside the address
    frame.delete();
    put_header(cur_id, 16'd1, 16'd1);
    put_question();
    put_answer(NAME_PTR, TYPE_A, ADDR_LEN);
    cut_to(HEADER_LEN + 1);
    send_datagram();
    frame.delete();
    put_header(cur_id, 16'd0, 16'd1);
    put_answer(NAME_PTR, TYPE_A, ADDR_LEN);
    cut_to(HEADER_LEN + 6);
    send_datagram();
    frame.delete();
    put_header(cur_id, 16'd0, 16'd1);
    put_answer(NAME_PTR, TYPE_A, ADDR_LEN);
    cut_to(frame.size() - 2);
    send_datagram();
    // address found, trailing bytes ignored
    frame.delete();
    put_header(cur_id, 16'd1, 16'd2);
    put_question();
    put_answer(NAME_STR, TYPE_A, ADDR_LEN);
    repeat (20) frame.push_back(8'($urandom));
    send_datagram();
    // oversize: an address followed by padding past the buffer
    frame.delete();
    put_header(cur_id, 16'd0, 16'd1);
    put_answer(NAME_ROOT, TYPE_A, ADDR_LEN);
    pad_to(MAX_BYTES + 8);
    send_datagram();

    phase_ids = '{16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom), ID_RESET};
    for (int p = 0; p < PHASES; p++) begin
      write_id(phase_ids[p]);
      target = bytes_sent + RANDOM_BYTES / PHASES;
      while (bytes_sent < target) begin
        build_random();
        send_datagram();
      end
      if (p == 0) begin
        // receiver holds off while short datagrams keep coming
        hold_req = 1'b1;
        repeat (8) begin
          frame.delete();
          put_header(cur_id, 16'd0, 16'd0);
          send_datagram();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
